// ===== rtl/bfge_pkg.sv =====
// Shared types and constants for the glyph expander.
// Used by the front, queue, back and top modules; depends on nothing.
`default_nettype none

package bfge_pkg;

  localparam int unsigned FONT_DEPTH_DEF = 2048;
  localparam int unsigned ADDR_MAX_W     = 12;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned ROW_W          = 8;
  localparam int unsigned CODE_W         = 8;
  localparam int unsigned DIM_W          = 4;
  localparam int unsigned LOAD_ADDR_W    = 11;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 8;

  localparam logic [DIM_W-1:0] GLYPH_MAX = 4'd8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // item action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHAR    = 2'd2;

  localparam logic [DIM_W-1:0]  GLYPH_WIDTH_RST  = 4'd8;
  localparam logic [DIM_W-1:0]  GLYPH_HEIGHT_RST = 4'd8;
  localparam logic [CODE_W-1:0] BASE_CHAR_RST    = 8'd32;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic                  is_load;
    logic [ADDR_MAX_W-1:0] addr;     // reduced font row index
    logic [ROW_W-1:0]      bits;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [COLOR_W-1:0]    fore;
    logic [COLOR_W-1:0]    back;
    logic                  opaque;
    logic [DIM_W-1:0]      w;        // saturated width
    logic [DIM_W-1:0]      h;        // saturated height
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
  } pix_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_REDUCE,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SCAN,
    B_FLUSH
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/bfge_front.sv =====
// Front end: accepts items, tracks the pen, reduces the font row index
// modulo the font depth. Depends on bfge_pkg.
`default_nettype none

module bfge_front #(
  parameter int unsigned FONT_DEPTH = bfge_pkg::FONT_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [bfge_pkg::DIM_W-1:0]             glyph_width,
  input  logic [bfge_pkg::DIM_W-1:0]             glyph_height,
  input  logic [bfge_pkg::CODE_W-1:0]            base_char,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   action,
  input  logic                                   start_req,
  input  logic signed [bfge_pkg::COORD_W-1:0]    pos_x,
  input  logic signed [bfge_pkg::COORD_W-1:0]    pos_y,
  input  logic [bfge_pkg::CODE_W-1:0]            char_code,
  input  logic [bfge_pkg::COLOR_W-1:0]           fore_color,
  input  logic [bfge_pkg::COLOR_W-1:0]           back_color,
  input  logic                                   opaque,
  input  logic [bfge_pkg::LOAD_ADDR_W-1:0]       font_addr,
  input  logic [bfge_pkg::ROW_W-1:0]             font_row,
  output logic                                   q_push,
  output bfge_pkg::cmd_t                         q_cmd,
  input  logic                                   q_full
);

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned VAL_LIMIT = 8192;
  // bias that lifts the most negative glyph offset above zero
  localparam int unsigned OFFS      = FONT_DEPTH * ((2048 + FONT_DEPTH - 1) / FONT_DEPTH);
  localparam int unsigned RED_STEPS = $clog2(VAL_LIMIT / FONT_DEPTH) + 2;
  localparam int unsigned K_W       = $clog2(RED_STEPS);

  bfge_pkg::front_state_t state, state_next;

  logic [K_W-1:0]              k;
  logic [VAL_W-1:0]            val;
  bfge_pkg::cmd_t              cmd;
  logic [bfge_pkg::COORD_W-1:0] pen_x;
  logic [bfge_pkg::COORD_W-1:0] pen_y;

  logic [bfge_pkg::DIM_W-1:0]  w_sat;
  logic [bfge_pkg::DIM_W-1:0]  h_sat;
  logic signed [8:0]           rel;
  logic signed [13:0]          prod;
  logic signed [VAL_W:0]       v_sum;
  logic [VAL_W-1:0]            sub;
  logic [bfge_pkg::COORD_W-1:0] pen_x_eff;
  logic [bfge_pkg::COORD_W-1:0] pen_y_eff;
  logic                        accept;

  assign w_sat = (glyph_width > bfge_pkg::GLYPH_MAX) ? bfge_pkg::GLYPH_MAX : glyph_width;
  assign h_sat = (glyph_height > bfge_pkg::GLYPH_MAX) ? bfge_pkg::GLYPH_MAX : glyph_height;
  assign rel   = $signed({1'b0, char_code}) - $signed({1'b0, base_char});
  assign prod  = $signed({1'b0, h_sat}) * rel;
  assign v_sum = (VAL_W+1)'(prod) + $signed((VAL_W+1)'(OFFS));
  assign sub   = VAL_W'(FONT_DEPTH) << k;

  assign pen_x_eff = start_req ? pos_x : pen_x;
  assign pen_y_eff = start_req ? pos_y : pen_y;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      bfge_pkg::F_IDLE: begin
        if (accept) state_next = bfge_pkg::F_REDUCE;
      end
      bfge_pkg::F_REDUCE: begin
        if (k == '0) state_next = bfge_pkg::F_PUSH;
      end
      bfge_pkg::F_PUSH: begin
        if (!q_full) state_next = bfge_pkg::F_IDLE;
      end
      default: state_next = bfge_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == bfge_pkg::F_IDLE);
    q_push     = (state == bfge_pkg::F_PUSH) && !q_full;
    q_cmd      = cmd;
    q_cmd.addr = bfge_pkg::ADDR_MAX_W'(val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfge_pkg::F_IDLE;
      k     <= '0;
      pen_x <= '0;
      pen_y <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        k <= K_W'(RED_STEPS - 1);
        if (action == bfge_pkg::ACT_DRAW) begin
          pen_x <= pen_x_eff + bfge_pkg::COORD_W'(w_sat);
          pen_y <= pen_y_eff;
        end
      end else if (state == bfge_pkg::F_REDUCE && k != '0) begin
        k <= k - 1'b1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.is_load <= (action == bfge_pkg::ACT_LOAD);
      cmd.addr    <= '0;
      cmd.bits    <= font_row;
      cmd.x       <= pen_x_eff;
      cmd.y       <= pen_y_eff;
      cmd.fore    <= fore_color;
      cmd.back    <= back_color;
      cmd.opaque  <= opaque;
      cmd.w       <= w_sat;
      cmd.h       <= h_sat;
      val         <= (action == bfge_pkg::ACT_DRAW) ? v_sum[VAL_W-1:0] : VAL_W'(font_addr);
    end else if (state == bfge_pkg::F_REDUCE && val >= sub) begin
      val <= val - sub;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfge_queue.sv =====
// Short command queue between front and back end.
// Depends on bfge_pkg for the command type and depth.
`default_nettype none

module bfge_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bfge_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output bfge_pkg::cmd_t rd_cmd,
  output logic           empty
);

  bfge_pkg::cmd_t entries [bfge_pkg::QUEUE_DEPTH];

  logic [bfge_pkg::QPTR_W-1:0] wr_ptr;
  logic [bfge_pkg::QPTR_W-1:0] rd_ptr;
  logic [bfge_pkg::QCNT_W-1:0] count;

  assign full   = (count == bfge_pkg::QCNT_W'(bfge_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/bfge_back.sv =====
// Back end: font memory, glyph row scan and pixel output register.
// Depends on bfge_pkg.
`default_nettype none

module bfge_back #(
  parameter int unsigned FONT_DEPTH = bfge_pkg::FONT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bfge_pkg::cmd_t                      q_cmd,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bfge_pkg::COORD_W-1:0] pixel_x,
  output logic signed [bfge_pkg::COORD_W-1:0] pixel_y,
  output logic [bfge_pkg::COLOR_W-1:0]        pixel_color,
  output logic                                last
);

  localparam int unsigned ADDR_W = $clog2(FONT_DEPTH);

  bfge_pkg::back_state_t state, state_next;

  logic [bfge_pkg::ROW_W-1:0] mem [FONT_DEPTH];
  logic [bfge_pkg::ROW_W-1:0] rd_data;
  logic [ADDR_W-1:0]          row_addr;
  logic [ADDR_W-1:0]          row_addr_next;
  bfge_pkg::cmd_t             cur;
  logic [2:0]                 row;
  logic [2:0]                 col;
  bfge_pkg::pix_t             pend;
  logic                       pend_valid;

  logic           mem_we;
  logic           start_draw;
  logic           rd_en;
  logic           out_free;
  logic           bit_set;
  logic           emit;
  logic           advance;
  logic           col_done;
  logic           row_done;
  logic           pend_load;
  logic           pend_drain;
  logic           out_load;
  logic           out_last;
  bfge_pkg::pix_t new_pix;

  assign row_addr_next = (row_addr == ADDR_W'(FONT_DEPTH - 1)) ? '0 : row_addr + 1'b1;
  assign col_done      = ({1'b0, col} == cur.w - 1'b1);
  assign row_done      = ({1'b0, row} == cur.h - 1'b1);

  always_comb begin
    state_next = state;
    unique case (state)
      bfge_pkg::B_IDLE: begin
        if (start_draw) state_next = bfge_pkg::B_FETCH;
      end
      bfge_pkg::B_FETCH: state_next = bfge_pkg::B_SCAN;
      bfge_pkg::B_SCAN: begin
        if (advance && col_done) begin
          state_next = row_done ? bfge_pkg::B_FLUSH : bfge_pkg::B_FETCH;
        end
      end
      bfge_pkg::B_FLUSH: begin
        if (!pend_valid || out_free) state_next = bfge_pkg::B_IDLE;
      end
      default: state_next = bfge_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state == bfge_pkg::B_IDLE) && !q_empty;
    mem_we     = q_pop && q_cmd.is_load;
    start_draw = q_pop && !q_cmd.is_load && (q_cmd.w != '0) && (q_cmd.h != '0);
    rd_en      = (state == bfge_pkg::B_FETCH);
    out_free   = !out_valid || out_ready;
    bit_set    = rd_data[col];
    emit       = bit_set || cur.opaque;
    // hold one pixel back so the final one can carry the last flag
    advance    = (state == bfge_pkg::B_SCAN) && !(emit && pend_valid && !out_free);
    pend_load  = advance && emit;
    pend_drain = (state == bfge_pkg::B_FLUSH) && pend_valid && out_free;
    out_load   = (pend_load && pend_valid) || pend_drain;
    out_last   = pend_drain;
    new_pix.x     = cur.x + bfge_pkg::COORD_W'(col);
    new_pix.y     = cur.y + bfge_pkg::COORD_W'(row);
    new_pix.color = bit_set ? cur.fore : cur.back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfge_pkg::B_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      row        <= '0;
      col        <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_drain) begin
        pend_valid <= 1'b0;
      end
      if (start_draw) begin
        row <= '0;
      end else if (advance && col_done) begin
        row <= row + 1'b1;
      end
      if (rd_en) begin
        col <= '0;
      end else if (advance && !col_done) begin
        col <= col + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_draw) begin
      cur      <= q_cmd;
      row_addr <= q_cmd.addr[ADDR_W-1:0];
    end else if (advance && col_done) begin
      row_addr <= row_addr_next;
    end
    if (pend_load) pend <= new_pix;
    if (out_load) begin
      pixel_x     <= pend.x;
      pixel_y     <= pend.y;
      pixel_color <= pend.color;
      last        <= out_last;
    end
  end

  // font memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[q_cmd.addr[ADDR_W-1:0]] <= q_cmd.bits;
    if (rd_en)  rd_data <= mem[row_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_font_glyph_expander_top.sv =====
// Glyph expander top: config registers, front end, queue, back end.
// Front: takes one item at a time and finishes it before taking the next.
// Back: writes a load item's row to font memory; scans a draw item row by row,
// one column per scan cycle while the output is taken, with a pixel for each
// set bit, or for every column when opaque.
// Reset (rst, sync, high): pen to zero, config to 8/8/32; font memory not cleared.
`default_nettype none

module bitmap_font_glyph_expander_top #(
  parameter int unsigned FONT_DEPTH = bfge_pkg::FONT_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [bfge_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bfge_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic                                  start_req,
  input  logic signed [bfge_pkg::COORD_W-1:0]   pos_x,
  input  logic signed [bfge_pkg::COORD_W-1:0]   pos_y,
  input  logic [bfge_pkg::CODE_W-1:0]           char_code,
  input  logic [bfge_pkg::COLOR_W-1:0]          fore_color,
  input  logic [bfge_pkg::COLOR_W-1:0]          back_color,
  input  logic                                  opaque,
  input  logic [bfge_pkg::LOAD_ADDR_W-1:0]      font_addr,
  input  logic [bfge_pkg::ROW_W-1:0]            font_row,
  // pixel items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bfge_pkg::COORD_W-1:0]   pixel_x,
  output logic signed [bfge_pkg::COORD_W-1:0]   pixel_y,
  output logic [bfge_pkg::COLOR_W-1:0]          pixel_color,
  output logic                                  last
);

  // Configuration registers. The user must write them only while the block is idle,
  // so front and back see a stable value per character; the block does not enforce it.
  logic [bfge_pkg::DIM_W-1:0]  glyph_width;
  logic [bfge_pkg::DIM_W-1:0]  glyph_height;
  logic [bfge_pkg::CODE_W-1:0] base_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= bfge_pkg::GLYPH_WIDTH_RST;
      glyph_height <= bfge_pkg::GLYPH_HEIGHT_RST;
      base_char    <= bfge_pkg::BASE_CHAR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bfge_pkg::REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[bfge_pkg::DIM_W-1:0];
        bfge_pkg::REG_GLYPH_HEIGHT: glyph_height <= cfg_data[bfge_pkg::DIM_W-1:0];
        bfge_pkg::REG_BASE_CHAR:    base_char    <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Front to back command queue. Load items travel through it too, so a
  // font write never overtakes or falls behind a draw issued around it.
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  bfge_pkg::cmd_t q_wr_cmd;
  bfge_pkg::cmd_t q_rd_cmd;

  // Front: takes items, advances the pen, reduces the glyph row index
  // modulo FONT_DEPTH one compare-and-subtract per cycle.
  bfge_front #(
    .FONT_DEPTH(FONT_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .base_char    (base_char),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .start_req    (start_req),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .char_code    (char_code),
    .fore_color   (fore_color),
    .back_color   (back_color),
    .opaque       (opaque),
    .font_addr    (font_addr),
    .font_row     (font_row),
    .q_push       (q_push),
    .q_cmd        (q_wr_cmd),
    .q_full       (q_full)
  );

  bfge_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  // Back: writes font rows, fetches one glyph row per pass and scans its
  // columns, one per cycle unless stalled, holding a pixel back to mark the last.
  bfge_back #(
    .FONT_DEPTH(FONT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_cmd       (q_rd_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (last)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_accept_no_push: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !q_push)
    else $error("item taken while front still pushing");
`endif

endmodule

`default_nettype wire
